// File: rtl/wqs_pkg.sv
package wqs_pkg;

    // Request codes
    localparam logic [2:0] REQ_SLEEP    = 3'd0;
    localparam logic [2:0] REQ_WAKE_ONE = 3'd1;
    localparam logic [2:0] REQ_SIGNAL   = 3'd2;
    localparam logic [2:0] REQ_WAKE_ALL = 3'd3;
    localparam logic [2:0] REQ_CLOSE    = 3'd4;
    localparam logic [2:0] REQ_CANCEL   = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_INTR     = 3'd2;
    localparam logic [2:0] ST_QUEUED   = 3'd3;
    localparam logic [2:0] ST_NOEFFECT = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Balance limits
    localparam logic signed [15:0] BAL_MAX = 16'sh7FFF;
    localparam logic signed [15:0] BAL_MIN = 16'sh8000;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] waiter_id;
        logic       no_deadline;
        logic       nonblocking;
        logic       interruptible;
        logic       composable;
        logic       cancel_cause;
    } t_in_item;

    typedef struct packed {
        logic [7:0] result_waiter;
        logic [2:0] status;
        logic       last;
    } t_out_item;

endpackage

// File: rtl/wqs_ram.sv
module wqs_ram import wqs_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int W     = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wait_queue_semaphore_engine.sv
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+---------------------------
// in       | i_in_valid / o_in_stall        | i_in  (t_in_item)
// out      | o_out_valid / i_out_stall      | o_out (t_out_item)
// cfg      | i_cfg_wr_en                    | i_cfg_wr_data (balance)
//
// One item at a time. Sleep and single-result requests pass through accept and
// dispatch; a head pop adds a read and an emit step per woken waiter, set by the
// one registered read port of the waiter memory. Cancel reads and checks each
// entry searched, then reads and writes back each later entry to close the gap.
// Synchronous active-low reset empties the queue, zeroes the balance and
// clears the closed flag; memory contents are not cleared.
// A stalled result holds the sequencer until the output register frees.
module wait_queue_semaphore_engine import wqs_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out,
    input  logic                i_cfg_wr_en,
    input  logic signed [15:0]  i_cfg_wr_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISP     = 3'd1;
    localparam logic [2:0] S_POP_RD   = 3'd2;
    localparam logic [2:0] S_POP_EMIT = 3'd3;
    localparam logic [2:0] S_SRCH_RD  = 3'd4;
    localparam logic [2:0] S_SRCH_CHK = 3'd5;
    localparam logic [2:0] S_SHIFT_RD = 3'd6;
    localparam logic [2:0] S_SHIFT_WR = 3'd7;

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);

    logic [2:0]          r_state, n_state;
    t_in_item            r_req, n_req;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_drain, n_drain;
    logic signed [15:0]  r_bal, n_bal;
    logic                r_closed, n_closed;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [EW-1:0]       mem_wdata, mem_rdata;

    logic                out_free;
    logic [ID_BITS-1:0]  req_id, rd_id;
    logic                rd_intr, rd_comp;
    logic signed [15:0]  bal_inc, bal_dec;
    logic [AW-1:0]       addr_tail, addr_idx, addr_next, head_next;
    logic [CW-1:0]       idx_plus;

    // Circular index: sum stays below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = (s >= DEPTH_A) ? (s - DEPTH_A) : s;
        return t[AW-1:0];
    endfunction

    wqs_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .W     (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Entry fields and shared address/balance arithmetic
    assign req_id    = ID_BITS'(r_req.waiter_id);
    assign rd_id     = mem_rdata[ID_BITS-1:0];
    assign rd_intr   = mem_rdata[ID_BITS];
    assign rd_comp   = mem_rdata[ID_BITS+1];
    assign idx_plus  = r_idx + CW'(1);
    assign addr_tail = wrap((AW+1)'(r_head) + (AW+1)'(r_count));
    assign addr_idx  = wrap((AW+1)'(r_head) + (AW+1)'(r_idx));
    assign addr_next = wrap((AW+1)'(r_head) + (AW+1)'(idx_plus));
    assign head_next = wrap((AW+1)'(r_head) + (AW+1)'(1));
    assign bal_inc   = (r_bal == BAL_MAX) ? r_bal : r_bal + 16'sd1;
    assign bal_dec   = (r_bal == BAL_MIN) ? r_bal : r_bal - 16'sd1;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_drain     = r_drain;
        n_bal       = r_bal;
        n_closed    = r_closed;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = addr_tail;
        mem_wdata   = {r_req.composable, r_req.interruptible, req_id};
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_req.req_type)
                    REQ_SLEEP: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out.result_waiter = 8'(req_id);
                            n_out.last = 1'b1;
                            n_state = S_IDLE;
                            if (r_closed) begin
                                n_out.status = ST_OK;
                            end else if (r_bal > 16'sd0) begin
                                n_bal = r_bal - 16'sd1;
                                n_out.status = ST_OK;
                            end else if (r_req.nonblocking && r_req.no_deadline) begin
                                if (r_req.composable) begin
                                    n_bal = bal_dec;
                                end
                                n_out.status = ST_TIMEOUT;
                            end else if (r_count >= DEPTH_C) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_out.status = ST_QUEUED;
                            end
                        end
                    end
                    REQ_WAKE_ONE: begin
                        if (!r_closed && r_bal >= 16'sd0 && r_count != '0) begin
                            n_drain = 1'b0;
                            n_state = S_POP_RD;
                        end else if (out_free) begin
                            if (!r_closed) begin
                                n_bal = bal_inc;
                            end
                            n_out_valid = 1'b1;
                            n_out = '{result_waiter: 8'd0, status: ST_NOEFFECT, last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    REQ_SIGNAL: begin
                        if (r_count != '0) begin
                            n_drain = 1'b0;
                            n_state = S_POP_RD;
                        end else if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{result_waiter: 8'd0, status: ST_NOEFFECT, last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    REQ_WAKE_ALL, REQ_CLOSE: begin
                        if (r_count != '0) begin
                            n_bal   = 16'sd0;
                            n_closed = r_closed || (r_req.req_type == REQ_CLOSE);
                            n_drain = 1'b1;
                            n_state = S_POP_RD;
                        end else if (out_free) begin
                            n_bal   = 16'sd0;
                            n_closed = r_closed || (r_req.req_type == REQ_CLOSE);
                            n_out_valid = 1'b1;
                            n_out = '{result_waiter: 8'd0, status: ST_NOEFFECT, last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    REQ_CANCEL: begin
                        if (r_count != '0) begin
                            n_idx   = '0;
                            n_state = S_SRCH_RD;
                        end else if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{result_waiter: 8'(req_id), status: ST_NOEFFECT,
                                      last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        // unused request codes
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out = '{result_waiter: 8'(req_id), status: ST_NOEFFECT,
                                      last: 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
                n_state   = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.result_waiter = 8'(rd_id);
                    n_out.status = ST_OK;
                    n_out.last = !r_drain || (r_count == CW'(1));
                    n_head  = head_next;
                    n_count = r_count - CW'(1);
                    n_state = (r_drain && r_count != CW'(1)) ? S_POP_RD : S_IDLE;
                end
            end
            S_SRCH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = addr_idx;
                n_state   = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (rd_id == req_id) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out.result_waiter = 8'(req_id);
                        n_out.last = 1'b1;
                        if (r_req.cancel_cause && !rd_intr) begin
                            n_out.status = ST_NOEFFECT;
                            n_state = S_IDLE;
                        end else begin
                            if (rd_comp) begin
                                n_bal = bal_dec;
                            end
                            n_out.status = r_req.cancel_cause ? ST_INTR : ST_TIMEOUT;
                            n_state = S_SHIFT_RD;
                        end
                    end
                end else if (idx_plus == r_count) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out = '{result_waiter: 8'(req_id), status: ST_NOEFFECT,
                                  last: 1'b1};
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx   = idx_plus;
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                // close the gap left by the removed entry
                if (idx_plus < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = addr_next;
                    n_state   = S_SHIFT_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_idx;
                mem_wdata = mem_rdata;
                n_idx     = idx_plus;
                n_state   = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write reloads the balance and reopens the queue
        if (i_cfg_wr_en) begin
            n_bal    = i_cfg_wr_data;
            n_closed = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_bal       <= 16'sd0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_bal       <= n_bal;
            r_closed    <= n_closed;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_drain <= n_drain;
        r_out   <= n_out;
    end

endmodule

// File: tb/sv/wqs_scoreboard_pkg.sv
`timescale 1ns / 1ps

package wqs_tb_pkg;
    import wqs_pkg::*;

    localparam int WAITER_SLOTS = 32;

    // Request codes the block must treat as no-ops
    localparam logic [2:0] REQ_RSVD_A = 3'd6;
    localparam logic [2:0] REQ_RSVD_B = 3'd7;

    // Tracks the wait queue state and the results the block still owes
    class wqs_scoreboard;
        logic [7:0]         slot_id   [WAITER_SLOTS];
        logic               slot_intr [WAITER_SLOTS];
        logic               slot_comp [WAITER_SLOTS];
        int                 occupancy      = 0;
        int                 peak_occupancy = 0;
        logic signed [15:0] balance        = '0;
        logic               closed         = 1'b0;
        t_out_item          owed[$];
        int                 errors         = 0;
        int                 checked        = 0;

        // Register write: reload balance, reopen the queue, keep the waiters
        function void load_balance(logic signed [15:0] value);
            balance = value;
            closed  = 1'b0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void balance_up();
            if (balance != BAL_MAX) balance = balance + 1;
        endfunction

        function void balance_down();
            if (balance != BAL_MIN) balance = balance - 1;
        endfunction

        function t_out_item outcome(logic [7:0] waiter, logic [2:0] status);
            return '{result_waiter: waiter, status: status, last: 1'b0};
        endfunction

        // Remove one entry, close the gap, return its id
        function logic [7:0] take_slot(int pos);
            logic [7:0] id;
            int         k;
            id = slot_id[pos];
            for (k = pos; k < occupancy - 1; k++) begin
                slot_id[k]   = slot_id[k + 1];
                slot_intr[k] = slot_intr[k + 1];
                slot_comp[k] = slot_comp[k + 1];
            end
            occupancy--;
            return id;
        endfunction

        // Accepted item: update the state and queue up its results
        function void note_request(t_in_item req);
            t_out_item  res[$];
            logic [7:0] id;
            int         hit;
            int         k;
            id = req.waiter_id;
            case (req.req_type)
                REQ_SLEEP: begin
                    if (closed) begin
                        res.push_back(outcome(id, ST_OK));
                    end else if (balance > 0) begin
                        balance = balance - 1;
                        res.push_back(outcome(id, ST_OK));
                    end else if (req.nonblocking && req.no_deadline) begin
                        // failed futex-style sleep leaves a debt if composable
                        if (req.composable) balance_down();
                        res.push_back(outcome(id, ST_TIMEOUT));
                    end else if (occupancy >= WAITER_SLOTS) begin
                        res.push_back(outcome(id, ST_FULL));
                    end else begin
                        slot_id[occupancy]   = id;
                        slot_intr[occupancy] = req.interruptible;
                        slot_comp[occupancy] = req.composable;
                        occupancy++;
                        if (occupancy > peak_occupancy) peak_occupancy = occupancy;
                        res.push_back(outcome(id, ST_QUEUED));
                    end
                end
                REQ_WAKE_ONE: begin
                    if (!closed && balance >= 0 && occupancy > 0) begin
                        res.push_back(outcome(take_slot(0), ST_OK));
                    end else begin
                        // banks a wakeup or repays a debt
                        if (!closed) balance_up();
                        res.push_back(outcome(8'd0, ST_NOEFFECT));
                    end
                end
                REQ_SIGNAL: begin
                    if (occupancy > 0) res.push_back(outcome(take_slot(0), ST_OK));
                    else res.push_back(outcome(8'd0, ST_NOEFFECT));
                end
                REQ_WAKE_ALL, REQ_CLOSE: begin
                    balance = '0;
                    if (req.req_type == REQ_CLOSE) closed = 1'b1;
                    if (occupancy == 0) res.push_back(outcome(8'd0, ST_NOEFFECT));
                    while (occupancy > 0) res.push_back(outcome(take_slot(0), ST_OK));
                end
                REQ_CANCEL: begin
                    // oldest entry with a matching id
                    hit = -1;
                    for (k = 0; k < occupancy; k++) begin
                        if (hit < 0 && slot_id[k] == id) hit = k;
                    end
                    if (hit < 0 || (req.cancel_cause && !slot_intr[hit])) begin
                        res.push_back(outcome(id, ST_NOEFFECT));
                    end else begin
                        if (slot_comp[hit]) balance_down();
                        void'(take_slot(hit));
                        res.push_back(outcome(id, req.cancel_cause ? ST_INTR : ST_TIMEOUT));
                    end
                end
                default: begin
                    res.push_back(outcome(id, ST_NOEFFECT));
                end
            endcase
            res[res.size() - 1].last = 1'b1;
            foreach (res[k]) owed.push_back(res[k]);
        endfunction

        // Accepted result: compare against the oldest owed one
        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (owed.size() == 0) begin
                $error("result with nothing owed: result_waiter %0d status %0d last %0d",
                       got.result_waiter, got.status, got.last);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.result_waiter !== want.result_waiter) begin
                $error("result_waiter: expected %0d, got %0d",
                       want.result_waiter, got.result_waiter);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/wait_queue_semaphore_engine_tb.sv
`timescale 1ns / 1ps

module wait_queue_semaphore_engine_tb;
    import wqs_pkg::*;
    import wqs_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int IDLE_MAX      = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 50;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    t_in_item           in_item     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    t_out_item          out_item;
    logic               cfg_wr_en   = 1'b0;
    logic signed [15:0] cfg_wr_data = '0;

    wqs_scoreboard sb;
    int in_gap_max    = 0;
    int out_gap_max   = 0;
    int hold_cycles   = 0;
    int requests_sent = 0;
    int settings_done = 0;
    int cycle_count   = 0;

    wait_queue_semaphore_engine dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in         (in_item),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out        (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor: values seen here are the ones before the edge
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_item);
    end

    // Result receiver: random stall per item, one long hold on request
    initial begin : result_receiver
        int wait_cycles;
        forever begin
            wait_cycles = $urandom_range(out_gap_max, 0);
            if (hold_cycles > 0) begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1 || out_stall);
        end
    end

    function automatic t_in_item req(logic [2:0] kind, logic [7:0] id, bit no_dl, bit nonblk,
                                     bit intr, bit comp, bit term);
        return '{req_type: kind, waiter_id: id, no_deadline: no_dl, nonblocking: nonblk,
                 interruptible: intr, composable: comp, cancel_cause: term};
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input t_in_item it);
        int gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_request(it);
        requests_sent++;
    endtask

    // Stop offering, wait for every owed result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_balance(input logic signed [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.load_balance(value);
        settings_done++;
    endtask

    // Random traffic under one balance setting, mostly small ids so cancels hit
    task automatic run_phase(input logic signed [15:0] start_balance);
        t_in_item it;
        int       pick;
        settle();
        write_balance(start_balance);
        in_gap_max  = $urandom_range(1, 0) ? IDLE_MAX : 0;
        out_gap_max = $urandom_range(1, 0) ? IDLE_MAX : 0;
        repeat (PHASE_ITEMS) begin
            it   = t_in_item'(16'($urandom));
            pick = $urandom_range(99, 0);
            if (pick < 40)      it.req_type = REQ_SLEEP;
            else if (pick < 60) it.req_type = REQ_CANCEL;
            else if (pick < 72) it.req_type = REQ_WAKE_ONE;
            else if (pick < 84) it.req_type = REQ_SIGNAL;
            else if (pick < 91) it.req_type = REQ_WAKE_ALL;
            else if (pick < 94) it.req_type = REQ_CLOSE;
            else it.req_type = $urandom_range(1, 0) ? REQ_RSVD_A : REQ_RSVD_B;
            if ($urandom_range(99, 0) < 85) it.waiter_id = 8'($urandom_range(7, 0));
            send_item(it);
        end
    endtask

    initial begin : stimulus
        int plan [7];
        sb   = new();
        plan = '{0, 1, -1, 4, -3, 32767, -32768};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one of each operation and the corner cases, no idling
        write_balance('0);
        send_item(req(REQ_SLEEP,    8'hFF, 0, 0, 1, 1, 0));
        send_item(req(REQ_SLEEP,    8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_SLEEP,    8'hFF, 1, 0, 0, 0, 0));  // duplicate id
        send_item(req(REQ_CANCEL,   8'hFF, 0, 0, 0, 0, 1));  // oldest FF, interrupted
        send_item(req(REQ_CANCEL,   8'h00, 0, 0, 0, 0, 1));  // not interruptible
        send_item(req(REQ_CANCEL,   8'h5A, 0, 0, 0, 0, 0));  // absent waiter
        send_item(req(REQ_WAKE_ONE, 8'h00, 0, 0, 0, 0, 0));  // repays the debt
        send_item(req(REQ_WAKE_ONE, 8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_SIGNAL,   8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_SIGNAL,   8'h00, 0, 0, 0, 0, 0));  // empty list
        send_item(req(REQ_SLEEP,    8'h33, 1, 1, 0, 1, 0));  // nonblocking timeout
        send_item(req(REQ_SLEEP,    8'h44, 0, 1, 1, 0, 0));  // nonblocking with deadline
        send_item(req(REQ_CANCEL,   8'h44, 0, 0, 0, 0, 0));  // deadline expired
        send_item(req(REQ_SLEEP,    8'h55, 0, 0, 0, 0, 0));
        send_item(req(REQ_WAKE_ALL, 8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_WAKE_ALL, 8'h00, 0, 0, 0, 0, 0));  // nothing to wake
        send_item(req(REQ_RSVD_A,   8'hA5, 1, 1, 1, 1, 1));
        send_item(req(REQ_WAKE_ONE, 8'h00, 0, 0, 0, 0, 0));  // banks a wakeup
        send_item(req(REQ_SLEEP,    8'h77, 0, 0, 0, 0, 0));  // consumes it
        send_item(req(REQ_SLEEP,    8'h01, 0, 0, 1, 0, 0));
        send_item(req(REQ_CLOSE,    8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_SLEEP,    8'h02, 0, 0, 0, 0, 0));  // closed: returns at once
        send_item(req(REQ_WAKE_ONE, 8'h00, 0, 0, 0, 0, 0));
        send_item(req(REQ_CLOSE,    8'h00, 0, 0, 0, 0, 0));  // close on empty list

        // Balance saturation at both ends
        settle();
        write_balance(BAL_MAX);
        send_item(req(REQ_WAKE_ONE, 8'h00, 0, 0, 0, 0, 0));
        settle();
        write_balance(BAL_MIN);
        send_item(req(REQ_SLEEP, 8'h33, 1, 1, 0, 1, 0));

        // Fill the list past capacity while the output is held off, then drain it
        settle();
        write_balance('0);
        in_gap_max  = 0;
        out_gap_max = IDLE_MAX;
        hold_cycles = HOLD_CYCLES;
        repeat (WAITER_SLOTS + 8) begin
            send_item(req(REQ_SLEEP, 8'($urandom_range(255, 0)), 0, 0,
                          1'($urandom), 1'($urandom), 0));
        end
        send_item(req(REQ_CLOSE, 8'h00, 0, 0, 0, 0, 0));

        // Random traffic over a spread of starting balances
        foreach (plan[k]) run_phase(16'(plan[k]));
        run_phase(16'($urandom_range(65535, 0)));

        settle();
        $display("Checked %0d results from %0d requests across %0d balance settings.",
                 sb.checked, requests_sent, settings_done);
        $display("Waiter list peaked at %0d of %0d entries; output held once for %0d cycles.",
                 sb.peak_occupancy, WAITER_SLOTS, HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
